[hw/rtl/idtb_pkg.sv]
// idtb_pkg: shared types and codes for the id table with backup
// used by idtb_ctrl and id_table_with_backup; depends on nothing else
package idtb_pkg;

   // command codes
   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_SEARCH  = 3'd1;
   localparam logic [2:0] CMD_REPLACE = 3'd2;
   localparam logic [2:0] CMD_DELETE  = 3'd3;
   localparam logic [2:0] CMD_BACKUP  = 3'd4;
   localparam logic [2:0] CMD_COMPARE = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_DIFFER    = 2'd3;

   localparam int unsigned ID_W = 32;

   typedef struct packed {
      logic [ID_W-1:0] new_id;
      logic [ID_W-1:0] id_value;
      logic [2:0]      command;
   } req_type;

   typedef struct packed {
      logic [5:0] live_count;
      logic [4:0] found_index;
      logic [1:0] status;
   } result_type;

endpackage

[hw/rtl/idtb_ram.sv]
// idtb_ram: simple dual-port table memory, one write and one read port
// read data registered; depends on nothing else
module idtb_ram #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = 5,
   parameter int unsigned DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/idtb_ctrl.sv]
// idtb_ctrl: command sequencer with the shared equality compare unit
// holds the live and backup tables (idtb_ram) and counts; uses idtb_pkg
module idtb_ctrl #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  idtb_pkg::req_type   req,
   output logic                idle,
   output logic                res_valid,
   input  logic                res_take,
   output idtb_pkg::result_type res
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_SHIFT = 6'b000100,
      S_COPY  = 6'b001000,
      S_CMP   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]              cmd_ff, cmd_in;
   logic [idtb_pkg::ID_W-1:0] key_ff, key_in, repl_ff, repl_in;
   logic [CW-1:0]           count_ff, count_in, bcount_ff, bcount_in;
   logic [CW-1:0]           ptr_ff, ptr_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [AW-1:0]           chk_idx_ff, chk_idx_in;
   logic [1:0]              status_ff, status_in;
   logic [AW-1:0]           index_ff, index_in;

   logic                      m_we, b_we;
   logic [AW-1:0]             m_waddr, b_waddr, rd_addr;
   logic [idtb_pkg::ID_W-1:0] m_wdata, b_wdata, m_rdata, b_rdata;
   logic [idtb_pkg::ID_W-1:0] cmp_b;
   logic                      cmp_eq;
   logic                      ptr_lt;

   idtb_ram #(.DEPTH(DEPTH), .AW(AW), .DW(idtb_pkg::ID_W)) u_live (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_addr (rd_addr),
      .rd_data (m_rdata)
   );

   idtb_ram #(.DEPTH(DEPTH), .AW(AW), .DW(idtb_pkg::ID_W)) u_backup (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (rd_addr),
      .rd_data (b_rdata)
   );

   // shared compare unit: key for scans, backup entry for compare
   assign cmp_b   = (state_ff == S_CMP) ? b_rdata : key_ff;
   assign cmp_eq  = (m_rdata == cmp_b);
   assign ptr_lt  = (ptr_ff < count_ff);
   assign rd_addr = ptr_ff[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      repl_in    = repl_ff;
      count_in   = count_ff;
      bcount_in  = bcount_ff;
      ptr_in     = ptr_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = ptr_ff[AW-1:0];
      status_in  = status_ff;
      index_in   = index_ff;
      m_we       = 1'b0;
      m_waddr    = chk_idx_ff;
      m_wdata    = m_rdata;
      b_we       = 1'b0;
      b_waddr    = chk_idx_ff;
      b_wdata    = m_rdata;
      res_valid  = 1'b0;

      // walk states read one entry a cycle and check it the next
      if ((state_ff == S_SCAN) || (state_ff == S_SHIFT) ||
          (state_ff == S_COPY) || (state_ff == S_CMP)) begin
         if (ptr_lt) begin
            ptr_in     = ptr_ff + CW'(1);
            chk_vld_in = 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req.command;
               key_in    = req.id_value;
               repl_in   = req.new_id;
               status_in = idtb_pkg::ST_OK;
               index_in  = '0;
               ptr_in    = '0;
               state_in  = S_DONE;
               unique case (req.command)
                  idtb_pkg::CMD_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = idtb_pkg::ST_FULL;
                     end else begin
                        m_we     = 1'b1;
                        m_waddr  = count_ff[AW-1:0];
                        m_wdata  = req.id_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  idtb_pkg::CMD_SEARCH, idtb_pkg::CMD_REPLACE,
                  idtb_pkg::CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = idtb_pkg::ST_NOT_FOUND;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  idtb_pkg::CMD_BACKUP: begin
                     bcount_in = count_ff;
                     if (count_ff != '0) begin
                        state_in = S_COPY;
                     end
                  end
                  idtb_pkg::CMD_COMPARE: begin
                     if (count_ff != bcount_ff) begin
                        status_in = idtb_pkg::ST_DIFFER;
                     end else if (count_ff != '0) begin
                        state_in = S_CMP;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (chk_vld_ff && cmp_eq) begin
               index_in   = chk_idx_ff;
               chk_vld_in = 1'b0;
               if (cmd_ff == idtb_pkg::CMD_REPLACE) begin
                  m_we     = 1'b1;
                  m_wdata  = repl_ff;
                  state_in = S_DONE;
               end else if (cmd_ff == idtb_pkg::CMD_DELETE) begin
                  ptr_in   = CW'(chk_idx_ff) + CW'(1);
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (!ptr_lt) begin
               status_in = idtb_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_SHIFT: begin
            if (chk_vld_ff) begin
               m_we    = 1'b1;
               m_waddr = chk_idx_ff - AW'(1);
            end
            if (!ptr_lt) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_COPY: begin
            if (chk_vld_ff) begin
               b_we = 1'b1;
            end
            if (!ptr_lt) begin
               state_in = S_DONE;
            end
         end
         S_CMP: begin
            if (chk_vld_ff && !cmp_eq) begin
               status_in  = idtb_pkg::ST_DIFFER;
               chk_vld_in = 1'b0;
               state_in   = S_DONE;
            end else if (!ptr_lt) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         bcount_ff  <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         bcount_ff  <= bcount_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      repl_ff    <= repl_in;
      ptr_ff     <= ptr_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      index_ff   <= index_in;
   end

   assign idle            = (state_ff == S_IDLE);
   assign res.status      = status_ff;
   assign res.found_index = 5'(index_ff);
   assign res.live_count  = 6'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(DEPTH)) && (bcount_ff <= CW'(DEPTH)))
      else $error("entry count beyond depth");

   a_live_write_in_range: assert property (@(posedge clock) disable iff (reset)
      m_we |-> (CW'(m_waddr) <= count_ff))
      else $error("table write beyond live entries");

   a_count_moves_on_insert_or_delete: assert property (@(posedge clock)
      disable iff (reset)
      !$stable(count_ff) |-> ($past(state_ff) == S_IDLE || $past(state_ff) == S_SHIFT))
      else $error("count changed outside insert or delete");

   a_backup_write_in_copy: assert property (@(posedge clock) disable iff (reset)
      b_we |-> (state_ff == S_COPY) && (CW'(b_waddr) < count_ff))
      else $error("backup written outside copy");

endmodule

[hw/rtl/id_table_with_backup.sv]
// id_table_with_backup: top level, stream ports and result register
// uses idtb_pkg and idtb_ctrl (which holds two idtb_ram tables)
//
// An unsorted table of up to DEPTH unsigned 32-bit IDs with a backup copy;
// each item on req carries one command and gives exactly one item on rsp.
// Commands are handled one at a time: insert, unknown commands and any
// command that needs no walk finish without walking the table; search,
// replace, backup and compare walk it, and delete walks it too (the scan
// stops at the match and the shift carries on from there, so the two
// together make one pass). A walk goes through the live entries by the
// single read port of each table memory, one entry per cycle through one
// shared equality comparator. A finished result sits in the output
// register, so the next item is taken while it waits on rsp. No item is
// taken in reset.
module id_table_with_backup #(
   parameter int unsigned DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // command[2:0], id_value[34:3], new_id[66:35], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], found_index[6:2], live_count[12:7], zero
);

   logic                 start, idle, res_valid, res_take;
   idtb_pkg::req_type    req;
   idtb_pkg::result_type res;
   idtb_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign req        = req_tdata[66:0];
   assign req_tready = idle && !reset;
   assign start      = req_tvalid && req_tready;

   idtb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .idle      (idle),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule
